FILE: hdl/antialiased_line_rasterizer_assert.svh
// assertion macros used by the rasterizer checker
// no dependencies; include by bare file name
`ifndef ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH
`define ANTIALIASED_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, disabled while the reset input is low
`define ALR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rasterizer assertion failed");

// next-cycle implication, disabled while the reset input is low
`define ALR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rasterizer assertion failed");

`endif

FILE: hdl/alr_pkg.sv
// shared types and constants of the anti-aliased line rasterizer
// no dependencies
package alr_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam int CFG_BITS = 13;
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd800;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd600;

  localparam int SHADE_BITS = 8;
  localparam logic [SHADE_BITS-1:0] SHADE_MAX = 8'd255;
  localparam int COLOUR_BITS = 24;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       sq_first;
    logic       sq_sum;
    logic       root_step;
    logic       snap;
    logic       div_init;
    logic       div_step;
    logic       emit;
    logic [1:0] idx;
  } alr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       active;
    logic       root_last;
    logic [2:0] pix_valid;
    logic       out_free;
  } alr_status_t;

endpackage

FILE: hdl/alr_ctrl.sv
// sequencer of the rasterizer: load, root, per-pixel divide and emit
// depends on alr_pkg
module alr_ctrl import alr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_op,
  output logic        in_tready,
  input  alr_status_t status,
  output alr_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQX   = 3'd1;
  localparam logic [2:0] S_SQY   = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_SQX;
          end else if (status.active) begin
            cmd.snap  = 1'b1;
            k_nxt     = 2'd0;
            state_nxt = S_DINIT;
          end
        end
      end
      S_SQX: begin
        cmd.sq_first = 1'b1;
        state_nxt    = S_SQY;
      end
      S_SQY: begin
        cmd.sq_sum = 1'b1;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_nxt = S_IDLE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = 3'd0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == 3'(SHADE_BITS - 1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (k_r == 2'd0 && status.pix_valid[1]) begin
            k_nxt     = 2'd1;
            state_nxt = S_DINIT;
          end else if (k_r != 2'd2 && status.pix_valid[2]) begin
            k_nxt     = 2'd2;
            state_nxt = S_DINIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 2'd0;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/alr_dp.sv
// datapath of the rasterizer: line state, square root, shade divider, output register
// depends on alr_pkg
module alr_dp import alr_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alr_cmd_t                      cmd,
  output alr_status_t                   status,
  input  logic                          cfg_wen,
  input  logic                          cfg_idx,
  input  logic [CFG_BITS-1:0]           cfg_wdata,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [COLOUR_BITS-1:0]        line_colour,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [SHADE_BITS-1:0]         shade,
  output logic                          on_screen,
  output logic [COLOUR_BITS-1:0]        pixel_colour,
  output logic                          last_of_step,
  output logic                          line_done
);

  localparam int CB = COORD_BITS;
  localparam int TB = CB + 1;
  localparam int SB = CB + 1;
  localparam int EB = CB + 3;
  localparam int WB = EB + 2;
  localparam int QB = 2 * SB + 1;
  localparam int RB = CB + 2;
  localparam int NB = RB + SHADE_BITS;
  localparam int VB = ((TB > CFG_BITS) ? TB : CFG_BITS) + 1;
  localparam logic [QB-1:0] ROOT_TOP = QB'(1) << (2 * SB);

  function automatic logic [WB-1:0] mag_of(input logic signed [WB-1:0] v);
    mag_of = (v < 0) ? WB'(-v) : WB'(v);
  endfunction

  // line state
  logic [CFG_BITS-1:0]   cfg_w_r, cfg_h_r;
  logic signed [CB-1:0]  cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [SB-1:0]         span_x_r, span_y_r;
  logic                  sxn_r, syn_r, zero_r, active_r, done_r;
  logic signed [EB-1:0]  err_r;
  logic [RB-1:0]         ed_r;
  logic [COLOUR_BITS-1:0] colour_r;

  // root, divider and per-step pixel registers
  logic [QB-1:0]         acc_r, rem_r, root_r, bit_r;
  logic signed [TB-1:0]  px_r [0:2];
  logic signed [TB-1:0]  py_r [0:2];
  logic [WB-1:0]         mag_r [0:2];
  logic [2:0]            valid_r;
  logic [RB-1:0]         div_rem_r;
  logic [SHADE_BITS-1:0] div_low_r, q_r;
  logic                  sat_r;

  // load arithmetic
  logic signed [TB-1:0] dxl, dyl;
  logic [SB-1:0]        axl, ayl;
  assign dxl = TB'(end_x) - TB'(start_x);
  assign dyl = TB'(end_y) - TB'(start_y);
  assign axl = (dxl < 0) ? SB'(-dxl) : SB'(dxl);
  assign ayl = (dyl < 0) ? SB'(-dyl) : SB'(dyl);

  logic [SB-1:0]     sq_op;
  logic [2*SB-1:0]   sq_w;
  assign sq_op = cmd.sq_first ? span_x_r : span_y_r;
  assign sq_w  = sq_op * sq_op;

  logic [QB-1:0] trial_root, root_n;
  logic          root_take;
  assign trial_root = root_r + bit_r;
  assign root_take  = rem_r >= trial_root;
  assign root_n     = root_take ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  // step evaluation
  logic signed [WB-1:0] e_w, dx_w, dy_w, ed_w, sum1, sum2, sum0, e_new;
  logic signed [TB-1:0] cx_t, cy_t, sx_t, sy_t, p1y, p2x;
  logic b1, b2, hitx, hity, mv1, mv2, done_w, v1, v2;
  assign e_w  = WB'(err_r);
  assign dx_w = signed'(WB'(span_x_r));
  assign dy_w = signed'(WB'(span_y_r));
  assign ed_w = signed'(WB'(ed_r));
  assign sum0 = e_w - dx_w + dy_w;
  assign sum1 = e_w + dy_w;
  assign sum2 = dx_w - e_w;
  assign b1   = (e_w + e_w) >= -dx_w;
  assign hitx = cur_x_r == goal_x_r;
  assign mv1  = b1 && !hitx;
  assign b2   = !(b1 && hitx) && ((e_w + e_w) <= dy_w);
  assign hity = cur_y_r == goal_y_r;
  assign mv2  = b2 && !hity;
  assign done_w = (b1 && hitx) || (b2 && hity);
  assign v1   = mv1 && (sum1 < ed_w);
  assign v2   = mv2 && (sum2 < ed_w);
  assign e_new = e_w - (mv1 ? dy_w : WB'(0)) + (mv2 ? dx_w : WB'(0));
  assign cx_t = TB'(cur_x_r);
  assign cy_t = TB'(cur_y_r);
  assign sx_t = sxn_r ? -TB'(1) : TB'(1);
  assign sy_t = syn_r ? -TB'(1) : TB'(1);
  assign p1y  = cy_t + sy_t;
  assign p2x  = cx_t + sx_t;

  // shade divider
  logic [WB-1:0] mag_s;
  logic [NB-1:0] num_w;
  logic [RB:0]   div_trial;
  logic          div_take;
  assign mag_s     = mag_r[cmd.idx];
  assign num_w     = (NB'(mag_s[RB-1:0]) << SHADE_BITS) - NB'(mag_s[RB-1:0]);
  assign div_trial = {div_rem_r, div_low_r[SHADE_BITS-1]};
  assign div_take  = div_trial >= {1'b0, ed_r};

  // screen test on the true coordinate
  logic signed [VB-1:0] pxv, pyv, wv, hv;
  logic                 last_w;
  assign pxv = VB'(px_r[cmd.idx]);
  assign pyv = VB'(py_r[cmd.idx]);
  assign wv  = signed'(VB'(cfg_w_r));
  assign hv  = signed'(VB'(cfg_h_r));
  assign last_w = (cmd.idx == 2'd2) || (cmd.idx == 2'd1 && !valid_r[2]) ||
                  (cmd.idx == 2'd0 && !valid_r[1] && !valid_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= WIDTH_RESET;
      cfg_h_r  <= HEIGHT_RESET;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      sxn_r    <= 1'b0;
      syn_r    <= 1'b0;
      err_r    <= '0;
      ed_r     <= RB'(1);
      colour_r <= '0;
      active_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        if (cfg_idx == CFG_IDX_WIDTH) cfg_w_r <= cfg_wdata;
        else cfg_h_r <= cfg_wdata;
      end
      if (cmd.load) begin
        cur_x_r  <= start_x;
        cur_y_r  <= start_y;
        goal_x_r <= end_x;
        goal_y_r <= end_y;
        span_x_r <= axl;
        span_y_r <= ayl;
        sxn_r    <= !(dxl > 0);
        syn_r    <= !(dyl > 0);
        err_r    <= EB'(axl) - EB'(ayl);
        colour_r <= line_colour;
        active_r <= 1'b1;
      end
      if (cmd.root_step && bit_r[0]) ed_r <= zero_r ? RB'(1) : RB'(root_n);
      if (cmd.snap) begin
        err_r    <= EB'(e_new);
        if (mv1) cur_x_r <= CB'(p2x);
        if (mv2) cur_y_r <= CB'(p1y);
        active_r <= !done_w;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) zero_r <= (axl == '0) && (ayl == '0);
    if (cmd.sq_first) acc_r <= QB'(sq_w);
    if (cmd.sq_sum) begin
      rem_r  <= acc_r + QB'(sq_w);
      root_r <= '0;
      bit_r  <= ROOT_TOP;
    end
    if (cmd.root_step) begin
      if (root_take) rem_r <= rem_r - trial_root;
      root_r <= root_n;
      bit_r  <= bit_r >> 2;
    end
    if (cmd.snap) begin
      px_r[0]  <= cx_t;     py_r[0] <= cy_t;
      px_r[1]  <= cx_t;     py_r[1] <= p1y;
      px_r[2]  <= p2x;      py_r[2] <= cy_t;
      mag_r[0] <= mag_of(sum0);
      mag_r[1] <= mag_of(sum1);
      mag_r[2] <= mag_of(sum2);
      valid_r  <= {v2, v1, 1'b1};
      done_r   <= done_w;
    end
    if (cmd.div_init) begin
      sat_r     <= mag_s >= WB'(ed_r);
      div_rem_r <= RB'(num_w[NB-1:SHADE_BITS]);
      div_low_r <= num_w[SHADE_BITS-1:0];
      q_r       <= '0;
    end
    if (cmd.div_step) begin
      div_rem_r <= div_take ? RB'(div_trial - {1'b0, ed_r}) : RB'(div_trial);
      q_r       <= {q_r[SHADE_BITS-2:0], div_take};
      div_low_r <= div_low_r << 1;
    end
    if (cmd.emit) begin
      pixel_x      <= CB'(px_r[cmd.idx]);
      pixel_y      <= CB'(py_r[cmd.idx]);
      shade        <= sat_r ? SHADE_MAX : q_r;
      on_screen    <= (pxv >= 0) && (pxv < wv) && (pyv >= 0) && (pyv < hv);
      pixel_colour <= colour_r;
      last_of_step <= last_w;
      line_done    <= done_r;
    end
  end

  assign status.active    = active_r;
  assign status.root_last = bit_r[0];
  assign status.pix_valid = valid_r;
  assign status.out_free  = !out_valid || out_tready;

endmodule

FILE: hdl/antialiased_line_rasterizer.sv
// top level of the anti-aliased line rasterizer: controller plus datapath
// depends on alr_pkg, alr_ctrl, alr_dp
//
//   channel | dir | handshake              | contents
//   in_     | in  | in_tvalid / in_tready  | tuser op, tdata endpoints and colour
//   out_    | out | out_tvalid / out_tready| tdata pixel, tlast end of step, tuser done
//   cfg_    | in  | cfg_wen                | screen width, screen height
//
// load word: spans squared and summed, then the 2-bit-a-cycle square root
// step word: a step is snapped; each pixel (up to 3) is shaded by the divider, emitted
// a step word with no active line is taken and emits nothing
// rst_n is synchronous; the output word register is free to stall, the
// sequencer waits at emit until the previous pixel is taken
module antialiased_line_rasterizer import alr_pkg::*; #(
  parameter int COORD_BITS = 13,
  localparam int IN_BITS  = 4 * COORD_BITS + COLOUR_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * COORD_BITS + SHADE_BITS + 1 + COLOUR_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // start_x, start_y, end_x, end_y, line_colour
  input  logic [IN_W-1:0]     in_tdata,
  // op
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // pixel_x, pixel_y, shade, on_screen, pixel_colour
  output logic [OUT_W-1:0]    out_tdata,
  output logic                out_tlast,
  // line_done
  output logic                out_tuser,
  input  logic                cfg_wen,
  input  logic                cfg_idx,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int CB = COORD_BITS;

  alr_cmd_t    cmd;
  alr_status_t status;

  logic signed [CB-1:0]   pixel_x, pixel_y;
  logic [SHADE_BITS-1:0]  shade;
  logic                   on_screen;
  logic [COLOUR_BITS-1:0] pixel_colour;

  // sequencer; op selects load or step
  alr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // all arithmetic and the output word register
  alr_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg_wen      (cfg_wen),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .start_x      (in_tdata[CB-1:0]),
    .start_y      (in_tdata[2*CB-1:CB]),
    .end_x        (in_tdata[3*CB-1:2*CB]),
    .end_y        (in_tdata[4*CB-1:3*CB]),
    .line_colour  (in_tdata[4*CB+COLOUR_BITS-1:4*CB]),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .shade        (shade),
    .on_screen    (on_screen),
    .pixel_colour (pixel_colour),
    .last_of_step (out_tlast),
    .line_done    (out_tuser)
  );

  // pack the output word, lowest field first, zero padded
  assign out_tdata = OUT_W'({pixel_colour, on_screen, shade, pixel_y, pixel_x});

endmodule

FILE: hdl/alr_checker.sv
// port-level checks of the anti-aliased line rasterizer, bound to the top level
// depends on alr_pkg and antialiased_line_rasterizer_assert.svh
`include "antialiased_line_rasterizer_assert.svh"

module alr_checker import alr_pkg::*; #(
  parameter int COORD_BITS = 13,
  localparam int OUT_BITS = 2 * COORD_BITS + SHADE_BITS + 1 + COLOUR_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser
);

  // stalled output word holds
  `ALR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // a load always keeps the input side busy for the root
  `ALR_ASSERT_NEXT(a_load_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser == OP_LOAD), !in_tready)

  // while a step still has pixels to come, no new word is taken
  `ALR_ASSERT_IMPLY(a_step_busy, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // reset empties the output register
  `ALR_ASSERT_NEXT(a_reset_quiet, clk, 1'b1, !rst_n, !out_tvalid)

endmodule

bind antialiased_line_rasterizer alr_checker #(.COORD_BITS(COORD_BITS)) u_alr_checker (.*);
